// ===== rtl/iambic_paddle_keyer_defines.svh =====
// ----------------------------------------------------------------------------
// Iambic paddle keyer assertion macros
// Shared concurrent assertion forms for the keyer RTL.
// ----------------------------------------------------------------------------
`ifndef IAMBIC_PADDLE_KEYER_DEFINES_SVH
`define IAMBIC_PADDLE_KEYER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define IPK_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyer assertion failed");

// Next-cycle implication, disabled in reset.
`define IPK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyer assertion failed");

`endif

// ===== rtl/ipk_pkg.sv =====
// ----------------------------------------------------------------------------
// Iambic paddle keyer package
// Types and constants shared by the keyer modules.
// ----------------------------------------------------------------------------
package ipk_pkg;

  localparam int CountW = 12;
  localparam int DitW = 11;
  localparam int ThrW = DitW + 2;
  localparam int CmpW = (CountW > ThrW) ? CountW : ThrW;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [DitW-1:0] DitReset = DitW'(60);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_KEY  = 2'd1,
    PH_GAP  = 2'd2
  } phase_t;

  typedef struct packed {
    logic dot_pressed;
    logic dash_pressed;
  } in_item_t;

  typedef struct packed {
    logic       key_out;
    logic [1:0] phase;
  } out_item_t;

endpackage

// ===== rtl/iambic_paddle_keyer.sv =====
// ----------------------------------------------------------------------------
// Iambic paddle keyer
// Tick-driven Morse paddle keyer with dot and dash memory.
// ----------------------------------------------------------------------------
// The keyer takes one tick item per clock cycle when the output is not
// stalled, and returns one result item per tick. An accepted item is
// captured in an input register; the keyer state, element timer and paddle
// memory then advance while the result is loaded into the output register,
// which happens once that register is free or being read. The output
// register lets a new tick enter while a result still waits. The dit length
// register may be written at any time the keyer has no tick in flight.

module iambic_paddle_keyer (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  ipk_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output ipk_pkg::out_item_t       out_data,
  input  logic                     cfg_wen,
  input  logic [ipk_pkg::DitW-1:0] cfg_wdata
);
  import ipk_pkg::*;

  logic             stage_valid;
  in_item_t         stage_item;
  logic             advance;
  logic [DitW-1:0]  dit_ticks;
  out_item_t        core_result;

  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      dit_ticks <= DitReset;
    end else if (cfg_wen) begin
      dit_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= core_result;
    end
  end

  ipk_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (stage_item),
    .dit_ticks (dit_ticks),
    .result    (core_result)
  );

endmodule

// ===== rtl/ipk_core.sv =====
// ----------------------------------------------------------------------------
// Iambic paddle keyer core
// Keyer state, element timer and paddle memory, advanced once per tick item.
// ----------------------------------------------------------------------------
`include "iambic_paddle_keyer_defines.svh"

module ipk_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  ipk_pkg::in_item_t      item,
  input  logic [ipk_pkg::DitW-1:0] dit_ticks,
  output ipk_pkg::out_item_t     result
);
  import ipk_pkg::*;

  phase_t            phase_reg;
  phase_t            phase_reg_next;
  logic [CountW-1:0] elapsed_ticks;
  logic [CountW-1:0] elapsed_ticks_next;
  logic              element_dot;
  logic              element_dot_next;
  logic              pending_dot;
  logic              pending_dot_next;
  logic              pending_dash;
  logic              pending_dash_next;

  logic [CountW-1:0] elapsed_inc;
  logic [ThrW-1:0]   dit_ext;
  logic [ThrW-1:0]   dash_len;
  logic [CmpW-1:0]   thr_sel;
  logic [CmpW-1:0]   thr_clip;
  logic              reached;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_IDLE;
      elapsed_ticks <= '0;
      element_dot   <= 1'b1;
      pending_dot   <= 1'b0;
      pending_dash  <= 1'b0;
    end else if (step) begin
      phase_reg     <= phase_reg_next;
      elapsed_ticks <= elapsed_ticks_next;
      element_dot   <= element_dot_next;
      pending_dot   <= pending_dot_next;
      pending_dash  <= pending_dash_next;
    end
  end

  always_comb begin
    elapsed_inc = (elapsed_ticks != CountMax) ? elapsed_ticks + 1'b1 : elapsed_ticks;
    dit_ext     = ThrW'(dit_ticks);
    dash_len    = (dit_ext << 1) + dit_ext;
    if (phase_reg == PH_KEY && !element_dot) begin
      thr_sel = CmpW'(dash_len);
    end else begin
      thr_sel = CmpW'(dit_ext);
    end
    thr_clip = (thr_sel > CmpW'(CountMax)) ? CmpW'(CountMax) : thr_sel;
    reached  = CmpW'(elapsed_inc) >= thr_clip;
  end

  always_comb begin
    phase_reg_next     = phase_reg;
    elapsed_ticks_next = elapsed_ticks;
    element_dot_next   = element_dot;
    pending_dot_next   = pending_dot;
    pending_dash_next  = pending_dash;
    case (phase_reg)
      PH_KEY: begin
        elapsed_ticks_next = elapsed_inc;
        if (reached) begin
          phase_reg_next     = PH_GAP;
          elapsed_ticks_next = '0;
          if (element_dot && item.dash_pressed) begin
            pending_dash_next = 1'b1;
          end
          if (!element_dot && item.dot_pressed) begin
            pending_dot_next = 1'b1;
          end
        end
      end
      PH_GAP: begin
        elapsed_ticks_next = elapsed_inc;
        if (reached) begin
          elapsed_ticks_next = '0;
          phase_reg_next     = PH_KEY;
          if (pending_dot) begin
            pending_dot_next = 1'b0;
            element_dot_next = 1'b1;
          end else if (pending_dash) begin
            pending_dash_next = 1'b0;
            element_dot_next  = 1'b0;
          end else if (item.dot_pressed) begin
            element_dot_next = 1'b1;
          end else if (item.dash_pressed) begin
            element_dot_next = 1'b0;
          end else begin
            phase_reg_next = PH_IDLE;
          end
        end
      end
      default: begin
        phase_reg_next = PH_IDLE;
        if (item.dot_pressed || item.dash_pressed) begin
          phase_reg_next     = PH_KEY;
          elapsed_ticks_next = '0;
          element_dot_next   = item.dot_pressed;
        end
      end
    endcase
  end

  assign result.key_out = (phase_reg_next == PH_KEY);
  assign result.phase   = phase_reg_next;

  `IPK_ASSERT_NEXT(a_hold_without_step, clk, rst, !step,
                   $stable(phase_reg) && $stable(elapsed_ticks) && $stable(pending_dot))
  `IPK_ASSERT_NEXT(a_idle_stays_idle, clk, rst,
                   step && phase_reg == PH_IDLE && !item.dot_pressed && !item.dash_pressed,
                   phase_reg == PH_IDLE)
  `IPK_ASSERT_NEXT(a_dot_starts_dot, clk, rst,
                   step && phase_reg == PH_IDLE && item.dot_pressed,
                   phase_reg == PH_KEY && element_dot && elapsed_ticks == '0)
  `IPK_ASSERT_NEXT(a_pending_dot_served, clk, rst,
                   step && phase_reg == PH_GAP && reached && pending_dot,
                   phase_reg == PH_KEY && element_dot && !pending_dot)
  `IPK_ASSERT_NEXT(a_key_goes_to_gap, clk, rst,
                   step && phase_reg == PH_KEY,
                   phase_reg == PH_KEY || phase_reg == PH_GAP)

endmodule

// ===== tb/iambic_paddle_keyer_test.sv =====
// ----------------------------------------------------------------------------
// Iambic paddle keyer testbench
// Drives tick items with random paddle patterns and random idle cycles on
// both handshakes. A local copy of the keyer predicts each result, and every
// result item is checked against the oldest prediction. Dit length covers the
// reset value, zero, small values and the all-ones value.
// ----------------------------------------------------------------------------
module iambic_paddle_keyer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ipk_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 8;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES = 64;
  localparam int RANDOM_ITEMS = 1050;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  localparam int DASH_DITS = 3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_wen = 1'b0;
  logic [DitW-1:0] cfg_wdata = '0;

  // Sender and receiver controls.
  logic quiet = 1'b0;
  logic hold_req = 1'b0;
  int hold_left = 0;
  int failures = 0;
  int cycles = 0;

  // Predicted keyer state.
  phase_t ph;
  logic [CountW-1:0] elapsed;
  logic elem_dot;
  logic mem_dot;
  logic mem_dash;
  logic [DitW-1:0] dit_len;

  out_item_t pending_results[$];

  iambic_paddle_keyer i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("iambic_paddle_keyer_test: FAIL");
      $finish;
    end
  end

  function automatic void begin_element(input logic is_dot);
    elem_dot = is_dot;
    ph = PH_KEY;
    elapsed = '0;
  endfunction

  // Saturating increment, then compare against the threshold clipped to the
  // largest count.
  function automatic logic count_done(input logic [ThrW-1:0] thr);
    logic [CmpW-1:0] lim;
    if (elapsed != CountMax) elapsed = elapsed + 1'b1;
    lim = (CmpW'(thr) > CmpW'(CountMax)) ? CmpW'(CountMax) : CmpW'(thr);
    return CmpW'(elapsed) >= lim;
  endfunction

  function automatic void keyer_step(input logic dot, input logic dash);
    logic [ThrW-1:0] len;
    out_item_t res;
    case (ph)
      PH_KEY: begin
        len = elem_dot ? ThrW'(dit_len) : ThrW'(dit_len) * ThrW'(DASH_DITS);
        if (count_done(len)) begin
          ph = PH_GAP;
          elapsed = '0;
          if (elem_dot && dash) mem_dash = 1'b1;
          if (!elem_dot && dot) mem_dot = 1'b1;
        end
      end
      PH_GAP: begin
        if (count_done(ThrW'(dit_len))) begin
          if (mem_dot) begin
            mem_dot = 1'b0;
            begin_element(1'b1);
          end else if (mem_dash) begin
            mem_dash = 1'b0;
            begin_element(1'b0);
          end else if (dot) begin
            begin_element(1'b1);
          end else if (dash) begin
            begin_element(1'b0);
          end else begin
            ph = PH_IDLE;
          end
        end
      end
      default: begin
        ph = PH_IDLE;
        if (dot) begin_element(1'b1);
        else if (dash) begin_element(1'b0);
      end
    endcase
    res.key_out = (ph == PH_KEY);
    res.phase = ph;
    pending_results.push_back(res);
  endfunction

  function automatic void note_failure(input string what, input out_item_t want,
                                       input out_item_t got);
    failures++;
    if (failures <= MAX_REPORTS)
      $display("%0t: %s: expected key_out=%b phase=%0d, got key_out=%b phase=%0d",
               $realtime, what, want.key_out, want.phase, got.key_out, got.phase);
  endfunction

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 20);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_failure("result with no tick waiting", '0, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.key_out !== want.key_out || out_data.phase !== want.phase)
          note_failure("result mismatch", want, out_data);
      end
    end
  end

  task automatic send_tick(input logic dot, input logic dash);
    in_item_t item;
    item.dot_pressed = dot;
    item.dash_pressed = dash;
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!(in_valid && in_ready));
    keyer_step(dot, dash);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_dit(input logic [DitW-1:0] value);
    drain_results();
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen <= 1'b0;
    dit_len = value;
  endtask

  task automatic test_default_dit();
    send_tick(1'b1, 1'b0);
    repeat (125) send_tick(1'b0, 1'b0);
  endtask

  task automatic test_zero_dit();
    set_dit('0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    repeat (4) send_tick(1'b1, 1'b1);
    repeat (2) send_tick(1'b0, 1'b0);
  endtask

  task automatic test_paddle_memory();
    set_dit(DitW'(2));
    repeat (20) send_tick(1'b1, 1'b1);
    repeat (6) send_tick(1'b0, 1'b0);
  endtask

  task automatic test_output_backpressure();
    set_dit(DitW'(1));
    @(posedge clk);
    hold_req = 1'b1;
    repeat (40) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    drain_results();
  endtask

  task automatic test_longest_dit();
    set_dit('1);
    send_tick(1'b0, 1'b1);
    repeat (150) send_tick(1'b0, 1'b0);
  endtask

  task automatic test_random_sequences();
    int sent;
    int chunk;
    int run_len;
    logic [1:0] paddles;
    sent = 0;
    for (int p = 0; sent < RANDOM_ITEMS; p++) begin
      case ($urandom_range(0, 9))
        0: set_dit('0);
        1: set_dit(DitW'($urandom_range(6, 12)));
        default: set_dit(DitW'($urandom_range(1, 4)));
      endcase
      quiet = (p == 3);
      chunk = 0;
      while (chunk < 150) begin
        if ($urandom_range(0, 99) < 80) begin
          paddles = 2'($urandom_range(0, 3));
          run_len = $urandom_range(1, 4 * dit_len + 3);
          repeat (run_len) send_tick(paddles[1], paddles[0]);
        end else begin
          run_len = $urandom_range(1, 6);
          repeat (run_len) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        chunk += run_len;
      end
      sent += chunk;
      quiet = 1'b0;
    end
  endtask

  initial begin
    ph = PH_IDLE;
    elapsed = '0;
    elem_dot = 1'b1;
    mem_dot = 1'b0;
    mem_dash = 1'b0;
    dit_len = DitReset;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    test_default_dit();
    test_zero_dit();
    test_paddle_memory();
    test_output_backpressure();
    test_longest_dit();
    test_random_sequences();
    drain_results();
    if (failures == 0) begin
      $display("iambic_paddle_keyer_test: PASS");
    end else begin
      $display("iambic_paddle_keyer_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ipk_pkg.sv
rtl/ipk_core.sv
rtl/iambic_paddle_keyer.sv
tb/iambic_paddle_keyer_test.sv
